>>> rtl/u8d_pkg.sv
// Shared types, constants and the lead byte classifier for the UTF-8 decoder.
// Used by the front, queue, back and top-level modules; no dependencies.
`default_nettype none

package u8d_pkg;

   localparam int unsigned QDEPTH   = 4;
   localparam int unsigned QPTR_W   = $clog2(QDEPTH);
   localparam int unsigned QCNT_W   = $clog2(QDEPTH + 1);

   localparam logic [20:0] REPL_CP  = 21'h00FFFD;
   localparam logic [20:0] MAX_CP   = 21'h10FFFF;
   localparam logic [20:0] SURR_LO  = 21'h00D800;
   localparam logic [20:0] SURR_HI  = 21'h00DFFF;
   localparam logic [20:0] LEAST_2  = 21'h000080;
   localparam logic [20:0] LEAST_3  = 21'h000800;
   localparam logic [20:0] LEAST_4  = 21'h010000;

   localparam logic [7:0]  CONT_MASK = 8'hC0;
   localparam logic [7:0]  CONT_TAG  = 8'h80;

   // Lead class: 0 for a single byte, 1 to 3 for the continuation bytes needed.
   localparam logic [2:0]  CLASS_BAD = 3'd4;

   typedef enum logic [1:0] {
      KIND_ASCII,
      KIND_BAD,
      KIND_MULTI
   } kind_type;

   // One planned result: what to emit and where its bytes sit in the window.
   typedef struct packed {
      kind_type   kind;
      logic [1:0] start;
      logic [1:0] extra;
   } plan_type;

   // One queued transaction: the byte window and the results it causes.
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      num;
      logic            last;
      plan_type [3:0]  plan;
   } entry_type;

   function automatic logic [2:0] lead_class(input logic [7:0] b);
      logic [2:0] k;
      priority if (b < 8'h80) k = 3'd0;
      else if (b < 8'hC0) k = CLASS_BAD;
      else if (b < 8'hE0) k = 3'd1;
      else if (b < 8'hF0) k = 3'd2;
      else if (b < 8'hF8) k = 3'd3;
      else k = CLASS_BAD;
      return k;
   endfunction

endpackage

`default_nettype wire

>>> rtl/u8d_front.sv
// Front end: holds the bytes of an unfinished sequence and splits each new
// byte window into planned results. Depends on u8d_pkg.
`default_nettype none

module u8d_front
   import u8d_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        accept,
   input  wire logic [7:0]  data_byte,
   input  wire logic        string_end,
   output entry_type        push_entry,
   output logic             push
);

   logic [2:0][7:0] pend_ff, pend_in;
   logic [1:0]      pend_cnt_ff, pend_cnt_in;

   logic [3:0][7:0] win;
   logic [2:0]      cnt;
   logic [2:0]      pos;
   logic [2:0]      n;
   logic            stop;
   logic            broken;
   logic [7:0]      lead;
   logic [2:0]      k;
   plan_type [3:0]  plan;

   always_comb begin
      cnt = 3'(pend_cnt_ff) + 3'd1;
      for (int i = 0; i < 4; i++) begin
         if (3'(i) < 3'(pend_cnt_ff)) begin
            win[i] = pend_ff[i < 3 ? i : 0];
         end else if (3'(i) == 3'(pend_cnt_ff)) begin
            win[i] = data_byte;
         end else begin
            win[i] = 8'h00;
         end
      end
   end

   // Walk the window the same way a whole-string scan would, at most four steps.
   always_comb begin
      pos    = 3'd0;
      n      = 3'd0;
      stop   = 1'b0;
      broken = 1'b0;
      lead   = 8'h00;
      k      = 3'd0;
      plan   = '0;
      for (int s = 0; s < 4; s++) begin
         if (!stop && pos < cnt) begin
            lead = win[pos[1:0]];
            k    = lead_class(lead);
            if (k == 3'd0) begin
               plan[n[1:0]] = '{kind: KIND_ASCII, start: pos[1:0], extra: 2'd0};
               n   = n + 3'd1;
               pos = pos + 3'd1;
            end else if (k == CLASS_BAD) begin
               plan[n[1:0]] = '{kind: KIND_BAD, start: pos[1:0], extra: 2'd0};
               n   = n + 3'd1;
               pos = pos + 3'd1;
            end else if ((cnt - pos) < (k + 3'd1)) begin
               if (!string_end) begin
                  stop = 1'b1;
               end else begin
                  // A sequence cut off by the string end collapses to one replacement.
                  plan[n[1:0]] = '{kind: KIND_BAD, start: pos[1:0], extra: 2'd0};
                  n   = n + 3'd1;
                  pos = cnt;
               end
            end else begin
               broken = 1'b0;
               for (int i = 1; i < 4; i++) begin
                  if (3'(i) <= k &&
                      (win[2'(pos + 3'(i))] & CONT_MASK) != CONT_TAG) begin
                     broken = 1'b1;
                  end
               end
               if (broken) begin
                  // Only the lead is consumed; the following bytes are rescanned.
                  plan[n[1:0]] = '{kind: KIND_BAD, start: pos[1:0], extra: 2'd0};
                  n   = n + 3'd1;
                  pos = pos + 3'd1;
               end else begin
                  plan[n[1:0]] = '{kind: KIND_MULTI, start: pos[1:0], extra: k[1:0]};
                  n   = n + 3'd1;
                  pos = pos + k + 3'd1;
               end
            end
         end
      end
   end

   always_comb begin
      pend_in     = pend_ff;
      pend_cnt_in = pend_cnt_ff;
      if (accept) begin
         if (stop && !string_end) begin
            pend_cnt_in = 2'(cnt - pos);
            for (int i = 0; i < 3; i++) begin
               pend_in[i] = win[2'(pos + 3'(i))];
            end
         end else begin
            pend_cnt_in = 2'd0;
         end
      end
   end

   always_comb begin
      push             = accept && (n != 3'd0);
      push_entry.bytes = win;
      push_entry.num   = n;
      push_entry.last  = string_end;
      push_entry.plan  = plan;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_cnt_ff <= 2'd0;
      end else begin
         pend_cnt_ff <= pend_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
   end

endmodule

`default_nettype wire

>>> rtl/u8d_queue.sv
// Short queue of planned transactions between the front and back ends.
// Depends on u8d_pkg for the entry type and depth.
`default_nettype none

module u8d_queue
   import u8d_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   push,
   input  entry_type   push_entry,
   input  wire logic   pop,
   output entry_type   head_entry,
   output logic        head_valid,
   output logic        full
);

   entry_type              store_ff [QDEPTH];
   logic [QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]      count_ff, count_in;

   logic do_push;
   logic do_pop;

   always_comb begin
      do_push   = push && !full;
      do_pop    = pop && head_valid;
      wr_ptr_in = do_push ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = QCNT_W'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = QCNT_W'(count_ff - 1'b1);
      end
   end

   assign full       = (count_ff == QCNT_W'(QDEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = store_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

>>> rtl/u8d_back.sv
// Back end: walks the planned results of the head transaction, decodes and
// range-checks each code point, and holds it in the output register. Uses u8d_pkg.
`default_nettype none

module u8d_back
   import u8d_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  entry_type          head_entry,
   input  wire logic          head_valid,
   output logic               pop,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output logic [20:0]        rsp_code_point,
   output logic               rsp_bad_sequence,
   output logic               rsp_run_last,
   output logic               rsp_string_done
);

   logic [1:0]  idx_ff, idx_in;
   logic        valid_ff, valid_in;
   logic [20:0] cp_ff, cp_in;
   logic        bad_ff, bad_in;
   logic        run_last_ff, run_last_in;
   logic        done_ff, done_in;

   plan_type    cur;
   logic [7:0]  b0, b1, b2, b3;
   logic [20:0] value;
   logic [20:0] least;
   logic        out_ready;
   logic        load;
   logic        last_res;

   always_comb begin
      cur = head_entry.plan[idx_ff];
      b0  = head_entry.bytes[cur.start];
      b1  = head_entry.bytes[2'(cur.start + 2'd1)];
      b2  = head_entry.bytes[2'(cur.start + 2'd2)];
      b3  = head_entry.bytes[2'(cur.start + 2'd3)];
      unique case (cur.extra)
         2'd1: begin
            value = {10'd0, b0[4:0], b1[5:0]};
            least = LEAST_2;
         end
         2'd2: begin
            value = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
            least = LEAST_3;
         end
         2'd3: begin
            value = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
            least = LEAST_4;
         end
         default: begin
            value = {13'd0, b0};
            least = 21'd0;
         end
      endcase
   end

   always_comb begin
      unique case (cur.kind)
         KIND_ASCII: begin
            cp_in  = {13'd0, b0};
            bad_in = 1'b0;
         end
         KIND_MULTI: begin
            if (value < least || value > MAX_CP ||
                (value >= SURR_LO && value <= SURR_HI)) begin
               cp_in  = REPL_CP;
               bad_in = 1'b1;
            end else begin
               cp_in  = value;
               bad_in = 1'b0;
            end
         end
         default: begin
            cp_in  = REPL_CP;
            bad_in = 1'b1;
         end
      endcase
   end

   always_comb begin
      out_ready   = !valid_ff || !rsp_stall;
      load        = head_valid && out_ready;
      last_res    = (3'(idx_ff) + 3'd1 == head_entry.num);
      pop         = load && last_res;
      run_last_in = last_res;
      done_in     = last_res && head_entry.last;
      idx_in      = idx_ff;
      if (load) begin
         idx_in = last_res ? 2'd0 : 2'(idx_ff + 2'd1);
      end
      valid_in = out_ready ? head_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cp_ff       <= cp_in;
         bad_ff      <= bad_in;
         run_last_ff <= run_last_in;
         done_ff     <= done_in;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_code_point   = cp_ff;
   assign rsp_bad_sequence = bad_ff;
   assign rsp_run_last     = run_last_ff;
   assign rsp_string_done  = done_ff;

endmodule

`default_nettype wire

>>> rtl/utf8_validating_decoder.sv
// UTF-8 validating decoder, top level: front end, transaction queue, back end.
// A byte's planned results are registered in the queue, then in the output register.
// Throughput: one byte per cycle while the queue is not full; the back end emits one
// result per cycle while not stalled, and the four-entry queue absorbs bursts.
// Reset (synchronous) clears the pending count, queue pointers and output valid.
// Depends on u8d_pkg, u8d_front, u8d_queue and u8d_back.
`default_nettype none

module utf8_validating_decoder
   import u8d_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_string_end,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [20:0]      rsp_code_point,
   output logic             rsp_bad_sequence,
   output logic             rsp_run_last,
   output logic             rsp_string_done
);

   entry_type push_entry;
   entry_type head_entry;
   logic      push;
   logic      pop;
   logic      head_valid;
   logic      q_full;
   logic      accept;

   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;

   u8d_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .data_byte  (req_data_byte),
      .string_end (req_string_end),
      .push_entry (push_entry),
      .push       (push)
   );

   u8d_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .head_valid (head_valid),
      .full       (q_full)
   );

   u8d_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_entry       (head_entry),
      .head_valid       (head_valid),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_code_point   (rsp_code_point),
      .rsp_bad_sequence (rsp_bad_sequence),
      .rsp_run_last     (rsp_run_last),
      .rsp_string_done  (rsp_string_done)
   );

   // The front end never offers a transaction that the queue cannot take.
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(push && q_full))
      else $error("transaction pushed into a full queue");

   a_done_is_run_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_string_done |-> rsp_run_last)
      else $error("string end flagged on a result that is not last for its byte");

   a_bad_is_repl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_sequence |-> rsp_code_point == REPL_CP)
      else $error("bad sequence flagged without a replacement character");

   a_scalar_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_code_point <= MAX_CP &&
                    (rsp_code_point < SURR_LO || rsp_code_point > SURR_HI))
      else $error("code point outside the Unicode scalar range");

endmodule

`default_nettype wire

>>> bench/tb_utf8_validating_decoder.sv
`timescale 1ns / 100ps
// Testbench for utf8_validating_decoder: directed and random byte strings, with
// a local decoder that predicts every code point. Depends on u8d_pkg and the RTL.

module tb_utf8_validating_decoder
   import u8d_pkg::*;
;

   localparam int unsigned BAD_LEAD    = int'(CLASS_BAD);
   localparam int          STALL_LIMIT = 1000;

   typedef struct packed {
      logic [20:0] code_point;
      logic        bad_sequence;
      logic        run_last;
      logic        string_done;
   } cp_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_string_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [20:0] rsp_code_point;
   logic        rsp_bad_sequence;
   logic        rsp_run_last;
   logic        rsp_string_done;

   // Local copy of the decoder's byte buffer.
   logic [7:0]  held_bytes [4];
   int unsigned held_count = 0;

   cp_result_type code_points_due [$];
   logic [7:0]    str_bytes [$];

   int  bytes_sent = 0;
   int  strings_sent = 0;
   int  results_seen = 0;
   int  fail_count = 0;
   bit  gaps_on = 1'b1;
   int  hold_request = 0;
   int  hold_left = 0;
   int  seg_left = 0;
   bit  seg_stall = 1'b0;

   utf8_validating_decoder u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_string_end   (req_string_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_code_point   (rsp_code_point),
      .rsp_bad_sequence (rsp_bad_sequence),
      .rsp_run_last     (rsp_run_last),
      .rsp_string_done  (rsp_string_done)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------- prediction

   function automatic int unsigned continuations_needed(input logic [7:0] b);
      if (b < 8'h80) return 0;
      else if (b < 8'hC0) return BAD_LEAD;
      else if (b < 8'hE0) return 1;
      else if (b < 8'hF0) return 2;
      else if (b < 8'hF8) return 3;
      return BAD_LEAD;
   endfunction

   function automatic cp_result_type make_result(input logic [20:0] cp, input logic bad);
      cp_result_type r;
      r.code_point   = cp;
      r.bad_sequence = bad;
      r.run_last     = 1'b0;
      r.string_done  = 1'b0;
      return r;
   endfunction

   task automatic drop_held(input int unsigned k);
      if (k >= held_count) begin
         held_count = 0;
      end else begin
         for (int i = 0; i < int'(held_count - k); i++) held_bytes[i] = held_bytes[i + k];
         held_count = held_count - k;
      end
   endtask

   // Assembles a complete sequence and rejects overlong, surrogate and
   // out-of-range values.
   function automatic cp_result_type assemble_sequence(input int unsigned extra);
      logic [31:0] v;
      logic [31:0] least;
      logic        bad;
      case (extra)
         1: begin
            v = {27'd0, held_bytes[0][4:0]};
            least = {11'd0, LEAST_2};
         end
         2: begin
            v = {28'd0, held_bytes[0][3:0]};
            least = {11'd0, LEAST_3};
         end
         default: begin
            v = {29'd0, held_bytes[0][2:0]};
            least = {11'd0, LEAST_4};
         end
      endcase
      for (int i = 1; i <= int'(extra); i++) v = (v << 6) | {26'd0, held_bytes[i][5:0]};
      bad = (v < least) || (v > {11'd0, MAX_CP}) ||
            (v >= {11'd0, SURR_LO} && v <= {11'd0, SURR_HI});
      return make_result(bad ? REPL_CP : v[20:0], bad);
   endfunction

   task automatic predict_code_points(input logic [7:0] b, input logic last);
      cp_result_type res [4];
      int            n;
      int unsigned   k;
      logic          broken;
      logic          waiting;
      n = 0;
      waiting = 1'b0;
      if (held_count > 3) held_count = 0;
      held_bytes[held_count] = b;
      held_count++;
      while (held_count > 0 && n < 4 && !waiting) begin
         k = continuations_needed(held_bytes[0]);
         if (k == 0) begin
            res[n] = make_result({13'd0, held_bytes[0]}, 1'b0);
            n++;
            drop_held(1);
         end else if (k == BAD_LEAD) begin
            res[n] = make_result(REPL_CP, 1'b1);
            n++;
            drop_held(1);
         end else if (held_count < k + 1) begin
            // An unfinished sequence waits for more bytes, or collapses at the end.
            if (!last) begin
               waiting = 1'b1;
            end else begin
               res[n] = make_result(REPL_CP, 1'b1);
               n++;
               held_count = 0;
            end
         end else begin
            broken = 1'b0;
            for (int i = 1; i <= int'(k); i++)
               if ((held_bytes[i] & CONT_MASK) != CONT_TAG) broken = 1'b1;
            if (broken) begin
               // Only the lead is replaced; the bytes after it are scanned again.
               res[n] = make_result(REPL_CP, 1'b1);
               n++;
               drop_held(1);
            end else begin
               res[n] = assemble_sequence(k);
               n++;
               drop_held(k + 1);
            end
         end
      end
      if (n > 0) begin
         res[n - 1].run_last = 1'b1;
         if (last) res[n - 1].string_done = 1'b1;
      end
      if (last) held_count = 0;
      for (int i = 0; i < n; i++) code_points_due.insert(code_points_due.size(), res[i]);
   endtask

   // ------------------------------------------------------------------ stimulus

   function automatic int pick_gap();
      int r;
      if (!gaps_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_data_byte  <= b;
      req_string_end <= last;
      do @(posedge clock); while (req_stall !== 1'b0);
      predict_code_points(b, last);
      bytes_sent++;
      if (last) strings_sent++;
   endtask

   // Sends the n low bytes of word, most significant first.
   task automatic send_bytes(input int n, input logic [31:0] word, input bit end_flag);
      for (int i = n - 1; i >= 0; i--) send_byte(word[8 * i +: 8], end_flag && i == 0);
   endtask

   task automatic send_str_bytes();
      for (int i = 0; i < str_bytes.size(); i++)
         send_byte(str_bytes[i], i == str_bytes.size() - 1);
   endtask

   task automatic drain_decoder();
      req_valid <= 1'b0;
      @(posedge clock);
      while (code_points_due.size() != 0) @(posedge clock);
   endtask

   task automatic append_byte(input logic [7:0] b);
      str_bytes.insert(str_bytes.size(), b);
   endtask

   // Encodes cp in exactly len bytes, without any check of the value.
   task automatic append_encoded(input logic [20:0] cp, input int len);
      case (len)
         1: append_byte({1'b0, cp[6:0]});
         2: begin
            append_byte({3'b110, cp[10:6]});
            append_byte({2'b10, cp[5:0]});
         end
         3: begin
            append_byte({4'b1110, cp[15:12]});
            append_byte({2'b10, cp[11:6]});
            append_byte({2'b10, cp[5:0]});
         end
         default: begin
            append_byte({5'b11110, cp[20:18]});
            append_byte({2'b10, cp[17:12]});
            append_byte({2'b10, cp[11:6]});
            append_byte({2'b10, cp[5:0]});
         end
      endcase
   endtask

   // Appends one unit to the string: mostly a well-formed character, else noise.
   task automatic add_unit();
      int          sel;
      int          len;
      logic [20:0] cp;
      logic [7:0]  b;
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
         len = $urandom_range(1, 4);
         case (len)
            1: cp = 21'($urandom_range(0, 'h7F));
            2: cp = 21'($urandom_range('h80, 'h7FF));
            3: begin
               cp = 21'($urandom_range('h800, 'hFFFF));
               if (cp >= SURR_LO && cp <= SURR_HI) cp = cp - 21'h800;
            end
            default: cp = 21'($urandom_range('h10000, 'h10FFFF));
         endcase
         append_encoded(cp, len);
      end else if (sel < 76) begin
         append_byte(8'($urandom_range(0, 255)));
      end else if (sel < 82) begin
         len = $urandom_range(2, 4);
         append_encoded(21'($urandom_range(0, 'h1FFFFF)), len);
         repeat ($urandom_range(1, len - 1)) void'(str_bytes.pop_back());
      end else if (sel < 88) begin
         case ($urandom_range(0, 2))
            0: begin
               len = $urandom_range(2, 4);
               cp = (len == 2) ? 21'($urandom_range(0, 'h7F)) :
                    (len == 3) ? 21'($urandom_range(0, 'h7FF)) :
                                 21'($urandom_range(0, 'hFFFF));
               append_encoded(cp, len);
            end
            1: append_encoded(21'($urandom_range('hD800, 'hDFFF)), 3);
            default: append_encoded(21'($urandom_range('h110000, 'h1FFFFF)), 4);
         endcase
      end else if (sel < 94) begin
         len = $urandom_range(2, 4);
         append_encoded(21'($urandom_range(0, 'h1FFFFF)), len);
         b = 8'($urandom_range(0, 191));
         if (b >= 8'h80) b = b + 8'h40;
         str_bytes[str_bytes.size() - len + $urandom_range(1, len - 1)] = b;
      end else begin
         b = $urandom_range(0, 1) ? 8'($urandom_range('h80, 'hBF)) :
                                    8'($urandom_range('hF8, 'hFF));
         append_byte(b);
      end
   endtask

   // --------------------------------------------------------------------- tests

   task automatic test_valid_forms();
      send_bytes(1, 32'h00, 1'b1);
      send_bytes(2, 32'hC280, 1'b0);
      // A genuine replacement character must not be flagged as bad.
      send_bytes(3, 32'hEFBFBD, 1'b0);
      send_bytes(4, 32'hF48FBFBF, 1'b1);
      drain_decoder();
   endtask

   task automatic test_invalid_forms();
      send_bytes(1, 32'h80, 1'b0);
      send_bytes(1, 32'hFF, 1'b0);
      send_bytes(2, 32'hC080, 1'b0);
      send_bytes(3, 32'hEDA080, 1'b0);
      send_bytes(4, 32'hF4908080, 1'b0);
      send_bytes(2, 32'hE27F, 1'b1);
      drain_decoder();
   endtask

   task automatic test_truncated_end();
      // The held bytes collapse into one replacement even though one is not
      // a continuation byte.
      send_bytes(2, 32'hF041, 1'b1);
      drain_decoder();
   endtask

   task automatic test_random_strings();
      int first;
      first = bytes_sent;
      while (bytes_sent - first < 160) begin
         gaps_on = ($urandom_range(0, 4) != 0);
         str_bytes.delete();
         repeat ($urandom_range(1, 10)) add_unit();
         send_str_bytes();
      end
      gaps_on = 1'b1;
      drain_decoder();
   endtask

   task automatic test_output_holdoff();
      hold_request = 80;
      gaps_on = 1'b0;
      str_bytes.delete();
      while (str_bytes.size() < 32) add_unit();
      send_str_bytes();
      gaps_on = 1'b1;
      drain_decoder();
   endtask

   // ------------------------------------------------------------------ checking

   task automatic check_result();
      cp_result_type got;
      cp_result_type want;
      got.code_point   = rsp_code_point;
      got.bad_sequence = rsp_bad_sequence;
      got.run_last     = rsp_run_last;
      got.string_done  = rsp_string_done;
      results_seen++;
      if (code_points_due.size() == 0) begin
         fail_count++;
         if (fail_count <= 10)
            $display("%0t: unexpected result cp=%06h bad=%0b last=%0b done=%0b", $time,
                     got.code_point, got.bad_sequence, got.run_last, got.string_done);
      end else begin
         want = code_points_due.pop_front();
         if (got.code_point !== want.code_point || got.bad_sequence !== want.bad_sequence ||
             got.run_last !== want.run_last || got.string_done !== want.string_done) begin
            fail_count++;
            if (fail_count <= 10) begin
               $display("%0t: mismatch expected cp=%06h bad=%0b last=%0b done=%0b",
                        $time, want.code_point, want.bad_sequence, want.run_last,
                        want.string_done);
               $display("%0t:          actual   cp=%06h bad=%0b last=%0b done=%0b",
                        $time, got.code_point, got.bad_sequence, got.run_last,
                        got.string_done);
            end
         end
      end
   endtask

   // Result side: checks each transaction and stalls in random segments, or for
   // a long hold-off when a test asks for one.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) check_result();
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (seg_left == 0) begin
               seg_stall = !seg_stall;
               if (seg_stall)
                  seg_left = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) :
                                                          $urandom_range(10, 30);
               else
                  seg_left = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 8) :
                                                          $urandom_range(20, 60);
            end
            seg_left--;
            rsp_stall <= seg_stall;
         end
      end
   end

   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid === 1'b1 && req_stall === 1'b0) ||
             (rsp_valid === 1'b1 && rsp_stall === 1'b0))
            idle = 0;
         else
            idle++;
      end
      $display("watchdog: %0d cycles without a transaction", idle);
      $display("tb: failure");
      $finish;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_valid_forms();
      test_invalid_forms();
      test_truncated_end();
      test_output_holdoff();
      test_random_strings();
      repeat (8) @(posedge clock);
      $display("Sent %0d bytes in %0d strings; checked %0d code points, %0d failures.",
               bytes_sent, strings_sent, results_seen, fail_count);
      $display("Covered valid and malformed forms, truncation, random strings, output hold-off.");
      if (fail_count == 0 && code_points_due.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
